// File: design/mrfd_pkg.sv
// Shared types and constants for the motor response frame decoder.
// Used by the frame tracker, the verdict stage and the top level.
package mrfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIRECTION = 3'd4;

  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST      = 8'd170;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST       = 8'd128;
  localparam logic [BYTE_W-1:0] NACK_CODE_RST      = 8'd129;
  localparam logic [BYTE_W-1:0] STATUS_CODE_RST    = 8'd130;
  localparam logic [BYTE_W-1:0] STOP_DIRECTION_RST = 8'd0;

  localparam logic [BYTE_W-1:0] POS_MAX       = 8'hFF;
  localparam logic [BYTE_W-1:0] SHORT_NACK    = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd4;
  localparam logic [BYTE_W-1:0] MIN_NACK_LEN  = 8'd2;
  localparam logic [BYTE_W-1:0] MIN_STAT_LEN  = 8'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] ack_code;
    logic [BYTE_W-1:0] nack_code;
    logic [BYTE_W-1:0] status_code;
    logic [BYTE_W-1:0] stop_direction;
  } cfg_t;

  // running state of the frame being received
  typedef struct packed {
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] xsum;
    logic              sync_ok;
    logic              cs_reached;
    logic              cs_match;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] pay0;
    logic [BYTE_W-1:0] pay1;
    logic [BYTE_W-1:0] pay2;
  } frm_t;

endpackage

// File: design/mrfd_track.sv
// Frame tracker: byte position, length, running XOR and captured bytes.
// Depends on mrfd_pkg.
module mrfd_track (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [mrfd_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         last_byte,
  input  logic [mrfd_pkg::BYTE_W-1:0]  sync_byte,
  output mrfd_pkg::frm_t               frm_nxt
);
  import mrfd_pkg::*;

  frm_t                frm_r;
  logic [BYTE_W:0]     cs_pos;
  logic [BYTE_W:0]     pos_ext;

  assign cs_pos  = {1'b0, frm_r.len} + (BYTE_W+1)'(2);
  assign pos_ext = {1'b0, frm_r.pos};

  always_comb begin
    frm_nxt = frm_r;
    if (frm_r.pos == '0) begin
      frm_nxt.sync_ok = (rx_byte == sync_byte);
    end else if (frm_r.pos == BYTE_W'(1)) begin
      frm_nxt.len  = rx_byte;
      frm_nxt.xsum = rx_byte;
    end else if (frm_r.pos != POS_MAX) begin
      if (frm_r.pos == BYTE_W'(2)) frm_nxt.code = rx_byte;
      if (frm_r.pos == BYTE_W'(3)) frm_nxt.pay0 = rx_byte;
      if (frm_r.pos == BYTE_W'(4)) frm_nxt.pay1 = rx_byte;
      if (frm_r.pos == BYTE_W'(5)) frm_nxt.pay2 = rx_byte;
      if (!frm_r.cs_reached) begin
        if (pos_ext == cs_pos) begin
          frm_nxt.cs_reached = 1'b1;
          frm_nxt.cs_match   = (frm_r.xsum == rx_byte);
        end else if (pos_ext < cs_pos) begin
          frm_nxt.xsum = frm_r.xsum ^ rx_byte;
        end
      end
    end
    // saturate the position count
    if (frm_r.pos != POS_MAX) frm_nxt.pos = frm_r.pos + BYTE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_r <= '0;
    end else if (step) begin
      if (last_byte) frm_r <= '0;
      else           frm_r <= frm_nxt;
    end
  end

endmodule

// File: design/mrfd_verdict.sv
// Verdict stage: checks the finished frame and holds the result register.
// Depends on mrfd_pkg.
module mrfd_verdict (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  mrfd_pkg::frm_t               frm,
  input  mrfd_pkg::cfg_t               cfg,
  input  logic [mrfd_pkg::BYTE_W-1:0]  motor,
  input  logic                         out_ready,
  output logic                         out_free,
  output logic                         out_valid,
  output logic                         out_frame_valid,
  output logic [mrfd_pkg::BYTE_W-1:0]  out_motor_echo,
  output logic [mrfd_pkg::BYTE_W-1:0]  out_response_code,
  output logic [mrfd_pkg::BYTE_W-1:0]  out_direction,
  output logic [mrfd_pkg::BYTE_W-1:0]  out_pwm_level,
  output logic [mrfd_pkg::BYTE_W-1:0]  out_status_byte
);
  import mrfd_pkg::*;

  logic              valid_r;
  logic              ok_r, ok_nxt;
  logic [BYTE_W-1:0] motor_r;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [BYTE_W-1:0] dir_r, dir_nxt;
  logic [BYTE_W-1:0] pwm_r, pwm_nxt;
  logic [BYTE_W-1:0] stat_r, stat_nxt;
  logic              passed;

  assign out_free = !valid_r || out_ready;
  assign passed   = (frm.pos >= MIN_FRAME_LEN) && frm.sync_ok && frm.cs_reached &&
                    frm.cs_match;

  always_comb begin
    ok_nxt   = 1'b0;
    code_nxt = '0;
    dir_nxt  = '0;
    pwm_nxt  = '0;
    stat_nxt = '0;
    if (passed) begin
      code_nxt = frm.code;
      // acknowledge wins over nack, nack over status
      if (frm.code == cfg.ack_code) begin
        ok_nxt  = 1'b1;
        dir_nxt = cfg.stop_direction;
      end else if (frm.code == cfg.nack_code) begin
        ok_nxt   = 1'b1;
        dir_nxt  = cfg.stop_direction;
        stat_nxt = (frm.len >= MIN_NACK_LEN) ? frm.pay0 : SHORT_NACK;
      end else if (frm.code == cfg.status_code && frm.len >= MIN_STAT_LEN) begin
        ok_nxt   = 1'b1;
        dir_nxt  = frm.pay0;
        pwm_nxt  = frm.pay1;
        stat_nxt = frm.pay2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r    <= ok_nxt;
      motor_r <= motor;
      code_r  <= code_nxt;
      dir_r   <= dir_nxt;
      pwm_r   <= pwm_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_frame_valid   = ok_r;
  assign out_motor_echo    = motor_r;
  assign out_response_code = code_r;
  assign out_direction     = dir_r;
  assign out_pwm_level     = pwm_r;
  assign out_status_byte   = stat_r;

endmodule

// File: design/motor_response_frame_decoder.sv
// Motor response frame decoder, top level: input register, config registers,
// frame tracker and verdict stage. Depends on mrfd_pkg, mrfd_track, mrfd_verdict.
// Throughput: one byte per cycle; a last byte holds in the input register while
// the previous result is still waiting, which stalls the input.
// A last byte's request is captured in the input register, then loaded into the result
// register once that is free, which raises out_valid.
// Reset (synchronous, active low) clears the frame state, both valids, and
// loads the configuration registers with their defaults.
module motor_response_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mrfd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          in_last_byte,
  input  logic [mrfd_pkg::BYTE_W-1:0]   in_motor_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_valid,
  output logic [mrfd_pkg::BYTE_W-1:0]   out_motor_echo,
  output logic [mrfd_pkg::BYTE_W-1:0]   out_response_code,
  output logic [mrfd_pkg::BYTE_W-1:0]   out_direction,
  output logic [mrfd_pkg::BYTE_W-1:0]   out_pwm_level,
  output logic [mrfd_pkg::BYTE_W-1:0]   out_status_byte,
  input  logic                          cfg_we,
  input  logic [mrfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrfd_pkg::BYTE_W-1:0]   cfg_data
);
  import mrfd_pkg::*;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic [BYTE_W-1:0] s1_motor_r;
  logic              s1_fire;
  logic              out_free;
  logic              in_accept;
  frm_t              frm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte      <= SYNC_BYTE_RST;
      cfg_r.ack_code       <= ACK_CODE_RST;
      cfg_r.nack_code      <= NACK_CODE_RST;
      cfg_r.status_code    <= STATUS_CODE_RST;
      cfg_r.stop_direction <= STOP_DIRECTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:      cfg_r.sync_byte      <= cfg_data;
        CFG_ACK_CODE:       cfg_r.ack_code       <= cfg_data;
        CFG_NACK_CODE:      cfg_r.nack_code      <= cfg_data;
        CFG_STATUS_CODE:    cfg_r.status_code    <= cfg_data;
        CFG_STOP_DIRECTION: cfg_r.stop_direction <= cfg_data;
        default: ;
      endcase
    end
  end

  // a last byte advances only when the result register can take it
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_rx_byte;
      s1_last_r  <= in_last_byte;
      s1_motor_r <= in_motor_number;
    end
  end

  mrfd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .sync_byte (cfg_r.sync_byte),
    .frm_nxt   (frm_nxt)
  );

  mrfd_verdict u_verdict (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (s1_fire && s1_last_r),
    .frm               (frm_nxt),
    .cfg               (cfg_r),
    .motor             (s1_motor_r),
    .out_ready         (out_ready),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_frame_valid   (out_frame_valid),
    .out_motor_echo    (out_motor_echo),
    .out_response_code (out_response_code),
    .out_direction     (out_direction),
    .out_pwm_level     (out_pwm_level),
    .out_status_byte   (out_status_byte)
  );

endmodule

// File: design/mrfd_chk.sv
// Port-level checker for the motor response frame decoder, bound to the top.
// Depends on mrfd_pkg.
module mrfd_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_frame_valid,
  input  logic [mrfd_pkg::BYTE_W-1:0]   out_motor_echo,
  input  logic [mrfd_pkg::BYTE_W-1:0]   out_response_code,
  input  logic [mrfd_pkg::BYTE_W-1:0]   out_direction,
  input  logic [mrfd_pkg::BYTE_W-1:0]   out_pwm_level,
  input  logic [mrfd_pkg::BYTE_W-1:0]   out_status_byte
);
  import mrfd_pkg::*;

  // a stalled result holds its whole payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_valid) &&
      $stable(out_motor_echo) && $stable(out_response_code) &&
      $stable(out_direction) && $stable(out_pwm_level) && $stable(out_status_byte))
    else $error("result changed while stalled");

  // a rejected frame reports no direction, pwm or status
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |->
      out_direction == '0 && out_pwm_level == '0 && out_status_byte == '0)
    else $error("invalid frame carries payload");

  // reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // a result does not appear in the cycle right after reset without a request
  a_no_early_result: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind motor_response_frame_decoder mrfd_chk u_mrfd_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_frame_valid   (out_frame_valid),
  .out_motor_echo    (out_motor_echo),
  .out_response_code (out_response_code),
  .out_direction     (out_direction),
  .out_pwm_level     (out_pwm_level),
  .out_status_byte   (out_status_byte)
);
